// ===== src/page_frame_allocator_defines.svh =====
// Assertion helpers shared by the allocator modules.
// Each module that uses them has i_clk and i_rst_n ports.
`ifndef PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("page frame allocator check failed");

// Next-cycle implication, checked outside reset.
`define PFA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("page frame allocator check failed");

`endif

// ===== src/pfa_pkg.sv =====
`default_nettype none

package pfa_pkg;

    localparam int ID_W    = 7;
    localparam int COUNT_W = 7;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ACTIVE  = 2'd1,
        ST_SHORT   = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef struct packed {
        logic              used;
        logic [ID_W-1:0]   owner;
    } t_frame_word;

    typedef struct packed {
        logic               start;
        t_kind              kind;
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] want;
    } t_scan_cmd;

    typedef struct packed {
        logic ready;
        logic done;
    } t_scan_stat;

    typedef struct packed {
        logic            rd_en;
        logic            wr_en;
        logic            wr_active;
        logic [ID_W-1:0] id;
    } t_proc_req;

    typedef struct packed {
        logic ready;
        logic in_range;
        logic active;
    } t_proc_stat;

endpackage

`default_nettype wire

// ===== src/pfa_frame_map.sv =====
`default_nettype none
`include "page_frame_allocator_defines.svh"

module pfa_frame_map
    import pfa_pkg::*;
#(
    parameter int NUM_FRAMES = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire t_scan_cmd                        i_cmd,
    output      t_scan_stat                       o_stat,
    output      logic [$clog2(NUM_FRAMES+1)-1:0]  o_count
);

    localparam int FAW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW  = $clog2(NUM_FRAMES + 1);
    localparam int XW  = CW + COUNT_W;

    t_frame_word r_mem [NUM_FRAMES];

    logic                r_clr;
    logic [FAW-1:0]      r_clr_addr;
    logic                r_rd_busy;
    logic [FAW-1:0]      r_rd_addr;
    t_frame_word         r_rd_data;
    logic                r_s1_vld;
    logic [FAW-1:0]      r_s1_addr;
    logic                r_s1_last;
    t_kind               r_kind;
    logic [ID_W-1:0]     r_id;
    logic [COUNT_W-1:0]  r_want;
    logic [CW-1:0]       r_got;
    logic                r_done;

    logic                clr_last;
    logic                rd_last;
    logic                hit;
    logic                wr_en;
    logic [FAW-1:0]      wr_addr;
    t_frame_word         wr_data;

    assign clr_last = (r_clr_addr == FAW'(NUM_FRAMES - 1));
    assign rd_last  = (r_rd_addr == FAW'(NUM_FRAMES - 1));

    // Shared compare: take the first free frames, or release frames owned by the id.
    always_comb begin
        unique case (r_kind)
            KIND_ALLOC: hit = !r_rd_data.used && (XW'(r_got) < XW'(r_want));
            KIND_FREE:  hit = r_rd_data.used && (r_rd_data.owner == r_id);
            default:    hit = 1'b0;
        endcase
    end

    assign wr_en   = r_clr || (r_s1_vld && hit);
    assign wr_addr = r_clr ? r_clr_addr : r_s1_addr;
    always_comb begin
        wr_data.used  = 1'b0;
        wr_data.owner = '0;
        if (!r_clr && r_kind == KIND_ALLOC) begin
            wr_data.used  = 1'b1;
            wr_data.owner = r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (r_rd_busy) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_rd_busy  <= 1'b0;
            r_rd_addr  <= '0;
            r_s1_vld   <= 1'b0;
            r_s1_addr  <= '0;
            r_s1_last  <= 1'b0;
            r_kind     <= KIND_ALLOC;
            r_id       <= '0;
            r_want     <= '0;
            r_got      <= '0;
            r_done     <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + FAW'(1);
                if (clr_last) begin
                    r_clr <= 1'b0;
                end
            end
            if (i_cmd.start) begin
                r_rd_busy <= 1'b1;
                r_rd_addr <= '0;
                r_kind    <= i_cmd.kind;
                r_id      <= i_cmd.id;
                r_want    <= i_cmd.want;
                r_got     <= '0;
            end else if (r_rd_busy) begin
                r_rd_addr <= r_rd_addr + FAW'(1);
                if (rd_last) begin
                    r_rd_busy <= 1'b0;
                end
            end
            r_s1_vld  <= r_rd_busy;
            r_s1_addr <= r_rd_addr;
            r_s1_last <= rd_last;
            if (r_s1_vld && hit) begin
                r_got <= r_got + CW'(1);
            end
            r_done <= r_s1_vld && r_s1_last;
        end
    end

    assign o_stat.ready = !r_clr;
    assign o_stat.done  = r_done;
    assign o_count      = r_got;

    `PFA_ASSERT_IMP(a_alloc_bound, r_kind == KIND_ALLOC, XW'(r_got) <= XW'(r_want))
    `PFA_ASSERT_IMP(a_no_scan_in_clear, r_clr, !r_s1_vld && !r_rd_busy)

endmodule

`default_nettype wire

// ===== src/pfa_proc_table.sv =====
`default_nettype none
`include "page_frame_allocator_defines.svh"

module pfa_proc_table
    import pfa_pkg::*;
#(
    parameter int MAX_PROCS = 128
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_proc_req  i_req,
    output      t_proc_stat o_stat
);

    localparam int PAW = $clog2(MAX_PROCS);
    localparam int IW  = PAW + ID_W + 1;

    logic r_mem [MAX_PROCS];

    logic           r_clr;
    logic [PAW-1:0] r_clr_addr;
    logic           r_rd_data;
    logic           r_rd_in;

    logic [IW-1:0]  id_ext;
    logic [PAW-1:0] idx;
    logic           in_range;
    logic           wr_en;
    logic [PAW-1:0] wr_addr;
    logic           wr_data;

    assign id_ext   = IW'(i_req.id);
    assign idx      = id_ext[PAW-1:0];
    assign in_range = (id_ext < IW'(MAX_PROCS));

    assign wr_en   = r_clr || (i_req.wr_en && in_range);
    assign wr_addr = r_clr ? r_clr_addr : idx;
    assign wr_data = !r_clr && i_req.wr_active;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[idx];
            r_rd_in   <= in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + PAW'(1);
            if (r_clr_addr == PAW'(MAX_PROCS - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    assign o_stat.ready    = !r_clr;
    assign o_stat.in_range = r_rd_in;
    assign o_stat.active   = r_rd_data && r_rd_in;

    `PFA_ASSERT_IMP(a_no_update_in_clear, r_clr, !i_req.wr_en && !i_req.rd_en)

endmodule

`default_nettype wire

// ===== src/page_frame_allocator.sv =====
// Page frame allocator: a bitmap of NUM_FRAMES frames with an owner id per frame.
// Input channel (i_valid/o_ready): i_kind selects allocate or free, i_process_id
// names the process, i_frame_count gives the frames wanted on allocate.
// Output channel (o_valid/i_ready): one result per input transaction with
// o_status, o_free_frames (free count after the transaction) and o_frames_changed.
// An allocate of an active id or an out-of-range id, a request larger than the free
// count, or a free of an unknown id changes nothing; its result goes from the check
// state through the done state to the output register, and o_ready is low till then.
// Any other transaction sweeps the frame memory one frame per cycle through one
// compare unit, and its result is registered after the sweep; one transaction
// is in flight at a time and o_ready stays low until its result is registered.
// A finished result waits in the output register while the receiver stalls; the
// next transaction may already be accepted and worked on, and its result is held
// back until the output register is free.
// After reset both tables are swept clear: o_ready stays low until both sweeps end,
// then every frame is free and no process is active.
`default_nettype none
`include "page_frame_allocator_defines.svh"

module page_frame_allocator
    import pfa_pkg::*;
#(
    parameter int NUM_FRAMES = 64,
    parameter int MAX_PROCS  = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output      logic               o_ready,
    input  wire logic               i_kind,
    input  wire logic [ID_W-1:0]    i_process_id,
    input  wire logic [COUNT_W-1:0] i_frame_count,
    output      logic               o_valid,
    input  wire logic               i_ready,
    output      logic [1:0]         o_status,
    output      logic [COUNT_W-1:0] o_free_frames,
    output      logic [COUNT_W-1:0] o_frames_changed
);

    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int XW = CW + COUNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DONE
    } t_state;

    t_state             r_state;
    t_kind              r_kind;
    logic [ID_W-1:0]    r_id;
    logic [COUNT_W-1:0] r_want;
    logic [CW-1:0]      r_free;
    t_status            r_res_status;
    logic [CW-1:0]      r_res_changed;
    logic               r_o_valid;
    t_status            r_o_status;
    logic [CW-1:0]      r_o_free;
    logic [CW-1:0]      r_o_changed;

    t_scan_cmd          scan_cmd;
    t_scan_stat         scan_stat;
    logic [CW-1:0]      scan_count;
    t_proc_req          proc_req;
    t_proc_stat         proc_stat;

    logic               accept;
    logic               short;
    logic [CW:0]        free_sum;
    logic [CW-1:0]      n_free;
    logic [XW-1:0]      free_ext;
    logic [XW-1:0]      changed_ext;

    assign o_ready = (r_state == S_IDLE) && scan_stat.ready && proc_stat.ready;
    assign accept  = i_valid && o_ready;

    assign short = !proc_stat.in_range || (XW'(r_want) > XW'(r_free));

    assign scan_cmd.start = (r_state == S_CHECK) && (
        (r_kind == KIND_ALLOC && !proc_stat.active && !short) ||
        (r_kind == KIND_FREE && proc_stat.active));
    assign scan_cmd.kind  = r_kind;
    assign scan_cmd.id    = r_id;
    assign scan_cmd.want  = r_want;

    assign proc_req.rd_en     = accept;
    assign proc_req.wr_en     = (r_state == S_SCAN) && scan_stat.done;
    assign proc_req.wr_active = (r_kind == KIND_ALLOC);
    assign proc_req.id        = (r_state == S_IDLE) ? i_process_id : r_id;

    // Saturate the free count on release.
    assign free_sum = (CW+1)'(r_free) + (CW+1)'(scan_count);
    always_comb begin
        unique case (r_kind)
            KIND_ALLOC: n_free = r_free - scan_count;
            KIND_FREE:  n_free = (free_sum > (CW+1)'(NUM_FRAMES)) ? CW'(NUM_FRAMES)
                                                                 : free_sum[CW-1:0];
            default:    n_free = r_free;
        endcase
    end

    pfa_frame_map #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_frame_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (scan_cmd),
        .o_stat  (scan_stat),
        .o_count (scan_count)
    );

    pfa_proc_table #(
        .MAX_PROCS (MAX_PROCS)
    ) u_proc_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (proc_req),
        .o_stat  (proc_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_kind        <= KIND_ALLOC;
            r_id          <= '0;
            r_want        <= '0;
            r_free        <= CW'(NUM_FRAMES);
            r_res_status  <= ST_OK;
            r_res_changed <= '0;
            r_o_valid     <= 1'b0;
            r_o_status    <= ST_OK;
            r_o_free      <= '0;
            r_o_changed   <= '0;
        end else begin
            if (r_o_valid && i_ready && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind  <= t_kind'(i_kind);
                        r_id    <= i_process_id;
                        r_want  <= i_frame_count;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_res_changed <= '0;
                    if (scan_cmd.start) begin
                        r_state <= S_SCAN;
                    end else begin
                        if (r_kind == KIND_FREE) begin
                            r_res_status <= ST_UNKNOWN;
                        end else if (proc_stat.active) begin
                            r_res_status <= ST_ACTIVE;
                        end else begin
                            r_res_status <= ST_SHORT;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (scan_stat.done) begin
                        r_free        <= n_free;
                        r_res_status  <= ST_OK;
                        r_res_changed <= scan_count;
                        r_state       <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold the result until the output register drains.
                    if (!r_o_valid || i_ready) begin
                        r_o_valid   <= 1'b1;
                        r_o_status  <= r_res_status;
                        r_o_free    <= r_free;
                        r_o_changed <= r_res_changed;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign free_ext         = XW'(r_o_free);
    assign changed_ext      = XW'(r_o_changed);
    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_free_frames    = free_ext[COUNT_W-1:0];
    assign o_frames_changed = changed_ext[COUNT_W-1:0];

    `PFA_ASSERT_IMP(a_free_bound, 1'b1, r_free <= CW'(NUM_FRAMES))
    `PFA_ASSERT_IMP(a_reject_no_change, r_o_valid && r_o_status != ST_OK, r_o_changed == '0)
    `PFA_ASSERT_NXT(a_scan_done_commits, r_state == S_SCAN && scan_stat.done,
                    r_state == S_DONE && r_res_status == ST_OK)

endmodule

`default_nettype wire
